>>> hdl/fpalu_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed-point ALU: fraction width, opcodes, divider sizing and
// the side-band record that travels beside the divider. No dependencies.
package fpalu_pkg;

  localparam int FRACTION_BITS = 8;

  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (32 + FRACTION_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_STAGES * DIV_STEP;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_INC      = 4'd4;
  localparam logic [3:0] OP_DEC      = 4'd5;
  localparam logic [3:0] OP_GT       = 4'd6;
  localparam logic [3:0] OP_LT       = 4'd7;
  localparam logic [3:0] OP_GE       = 4'd8;
  localparam logic [3:0] OP_LE       = 4'd9;
  localparam logic [3:0] OP_EQ       = 4'd10;
  localparam logic [3:0] OP_NE       = 4'd11;
  localparam logic [3:0] OP_MIN      = 4'd12;
  localparam logic [3:0] OP_MAX      = 4'd13;
  localparam logic [3:0] OP_TO_INT   = 4'd14;
  localparam logic [3:0] OP_FROM_INT = 4'd15;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] res;
    logic        cmp;
    logic        ovf;
    logic        neg;
    logic        dz;
  } side_t;

endpackage

>>> hdl/fpalu_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for magnitudes, two quotient bits per stage.
// Depends on fpalu_pkg for the fraction width and the stage count.
module fpalu_divider (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              num_mag,
  input  logic [31:0]              den_mag,
  output logic [fpalu_pkg::DIV_W-1:0] quo,
  output logic [32:0]              rem,
  output logic [31:0]              den_out
);
  import fpalu_pkg::*;

  logic [32:0]      rem_r [DIV_STAGES];
  logic [DIV_W-1:0] quo_r [DIV_STAGES];
  logic [DIV_W-1:0] dvd_r [DIV_STAGES];
  logic [31:0]      den_r [DIV_STAGES];

  logic [DIV_W-1:0] dvd_init;

  assign dvd_init = DIV_W'(num_mag) << FRACTION_BITS;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0]      rem_in;
    logic [DIV_W-1:0] quo_in;
    logic [DIV_W-1:0] dvd_in;
    logic [31:0]      den_in;
    logic [32:0]      rem_nxt;
    logic [DIV_W-1:0] quo_nxt;
    logic [DIV_W-1:0] dvd_nxt;

    if (k == 0) begin : g_first
      assign rem_in = 33'd0;
      assign quo_in = '0;
      assign dvd_in = dvd_init;
      assign den_in = den_mag;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      dvd_nxt = dvd_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        rem_nxt = {rem_nxt[31:0], dvd_nxt[DIV_W-1]};
        dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, den_in}) begin
          rem_nxt = rem_nxt - {1'b0, den_in};
          quo_nxt = {quo_nxt[DIV_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        dvd_r[k] <= dvd_nxt;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo     = quo_r[DIV_STAGES-1];
  assign rem     = rem_r[DIV_STAGES-1];
  assign den_out = den_r[DIV_STAGES-1];

endmodule

>>> hdl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Every item passes through the divider pipeline and one transfer is taken per
// cycle. The whole pipeline advances together and holds while a result waits.
// Synchronous active-low reset clears the valid bits; data registers keep
// their contents. Depends on fpalu_pkg and fpalu_divider.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  in_tuser,   // opcode [3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value [31:0]
  output logic [2:0]  out_tuser   // compare_true [0], divide_by_zero [1], overflow [2]
);
  import fpalu_pkg::*;

  localparam logic [63:0] HALF = 64'((64'd1 << FRACTION_BITS) >> 1);

  function automatic logic [32:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - mag[31:0]};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_s64(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sh7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -64'sh8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  logic adv;
  logic out_valid_r;
  logic [31:0] out_data_r;
  logic [2:0]  out_user_r;

  logic vld_r [DIV_STAGES+1];
  logic [3:0]         op0_r;
  logic signed [31:0] a0_r;
  logic signed [31:0] b0_r;

  side_t side_r [DIV_STAGES];
  logic signed [63:0] prod_r;

  logic [31:0] a_mag;
  logic [31:0] b_mag;
  side_t       side1_nxt;
  side_t       side2_nxt;
  logic [63:0] mul_mag;
  logic [63:0] mul_q;
  logic [32:0] mul_sat;

  logic [DIV_W-1:0] quo;
  logic [32:0]      rem;
  logic [31:0]      den;
  logic             round_up;
  logic [DIV_W:0]   quo_rnd;
  logic [32:0]      div_sat;
  logic [31:0]      out_data_nxt;
  logic [2:0]       out_user_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i <= DIV_STAGES; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= in_tuser;
      a0_r  <= in_tdata[31:0];
      b0_r  <= in_tdata[63:32];
    end
  end

  assign a_mag = a0_r[31] ? 32'd0 - a0_r : a0_r;
  assign b_mag = b0_r[31] ? 32'd0 - b0_r : b0_r;

  always_comb begin
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic [32:0] s;
    a64 = {{32{a0_r[31]}}, a0_r};
    b64 = {{32{b0_r[31]}}, b0_r};
    s = 33'd0;
    side1_nxt     = '0;
    side1_nxt.op  = op0_r;
    side1_nxt.neg = a0_r[31] ^ b0_r[31];
    side1_nxt.dz  = (b0_r == 32'sd0);
    case (op0_r)
      OP_ADD:      s = sat_s64(a64 + b64);
      OP_SUB:      s = sat_s64(a64 - b64);
      OP_INC:      s = sat_s64(a64 + 64'sd1);
      OP_DEC:      s = sat_s64(a64 - 64'sd1);
      OP_GT:       side1_nxt.cmp = (a0_r > b0_r);
      OP_LT:       side1_nxt.cmp = (a0_r < b0_r);
      OP_GE:       side1_nxt.cmp = (a0_r >= b0_r);
      OP_LE:       side1_nxt.cmp = (a0_r <= b0_r);
      OP_EQ:       side1_nxt.cmp = (a0_r == b0_r);
      OP_NE:       side1_nxt.cmp = (a0_r != b0_r);
      OP_MIN:      s = {1'b0, (a0_r < b0_r) ? a0_r : b0_r};
      OP_MAX:      s = {1'b0, (a0_r > b0_r) ? a0_r : b0_r};
      OP_TO_INT:   s = {1'b0, 32'(a0_r >>> FRACTION_BITS)};
      OP_FROM_INT: s = sat_s64(a64 <<< FRACTION_BITS);
      default:     s = 33'd0;
    endcase
    side1_nxt.ovf = s[32];
    side1_nxt.res = s[31:0];
  end

  assign mul_mag = prod_r[63] ? 64'd0 - prod_r : prod_r;
  assign mul_q   = (mul_mag + HALF) >> FRACTION_BITS;
  assign mul_sat = sat_mag(mul_q, prod_r[63]);

  always_comb begin
    side2_nxt = side_r[0];
    if (side_r[0].op == OP_MUL) begin
      side2_nxt.res = mul_sat[31:0];
      side2_nxt.ovf = mul_sat[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r    <= a0_r * b0_r;
      side_r[0] <= side1_nxt;
      side_r[1] <= side2_nxt;
      for (int i = 2; i < DIV_STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  fpalu_divider u_div (
    .clk     (clk),
    .en      (adv),
    .num_mag (a_mag),
    .den_mag (b_mag),
    .quo     (quo),
    .rem     (rem),
    .den_out (den)
  );

  assign round_up = ({rem, 1'b0} >= {2'b00, den});
  assign quo_rnd  = {1'b0, quo} + {{DIV_W{1'b0}}, round_up};
  assign div_sat  = sat_mag({{(63 - DIV_W){1'b0}}, quo_rnd}, side_r[DIV_STAGES-1].neg);

  always_comb begin
    side_t s;
    s = side_r[DIV_STAGES-1];
    out_data_nxt = s.res;
    out_user_nxt = {s.ovf, 1'b0, s.cmp};
    if (s.op == OP_DIV) begin
      if (s.dz) begin
        out_data_nxt = 32'd0;
        out_user_nxt = 3'b010;
      end else begin
        out_data_nxt = div_sat[31:0];
        out_user_nxt = {div_sat[32], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

>>> tb/fpalu_checker.sv
`timescale 1ns / 1ps
// Checker for the fixed-point ALU: watches both stream channels, predicts each
// result from the accepted operands and compares. Depends on fpalu_pkg.
module fpalu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending
);
  import fpalu_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
    logic        ovf;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x,
                                                  inout logic ovf);
    if (x > 66'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end else if (x < -66'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  function automatic alu_result_t alu_predict(input logic [3:0] op,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    logic signed [65:0] wa, wb, p, q;
    logic [65:0] mag, n, d;
    logic neg;
    r = '0;
    wa = a;
    wb = b;
    case (op)
      OP_ADD: r.value = clamp32(wa + wb, r.ovf);
      OP_SUB: r.value = clamp32(wa - wb, r.ovf);
      OP_INC: r.value = clamp32(wa + 1, r.ovf);
      OP_DEC: r.value = clamp32(wa - 1, r.ovf);
      OP_MUL: begin
        p = wa * wb;
        mag = p < 0 ? -p : p;
        mag = (mag + ((66'd1 << FRACTION_BITS) >> 1)) >> FRACTION_BITS;
        q = mag;
        r.value = clamp32(p < 0 ? -q : q, r.ovf);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          n = (wa < 0 ? -wa : wa) << FRACTION_BITS;
          d = wb < 0 ? -wb : wb;
          q = (2 * n + d) / (2 * d);
          neg = (a < 0) != (b < 0);
          r.value = clamp32(neg ? -q : q, r.ovf);
        end
      end
      OP_GT: r.cmp = a > b;
      OP_LT: r.cmp = a < b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = a < b ? a : b;
      OP_MAX: r.value = a > b ? a : b;
      OP_TO_INT: r.value = a >>> FRACTION_BITS;
      default: r.value = clamp32(wa <<< FRACTION_BITS, r.ovf);
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(alu_predict(in_tuser, in_tdata[31:0], in_tdata[63:32]));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected result transfer: %h", out_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata !== exp_r.value || out_tuser !== {exp_r.ovf, exp_r.dz, exp_r.cmp}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected value %h cmp %b dz %b ovf %b, got %h cmp %b dz %b ovf %b",
                     exp_r.value, exp_r.cmp, exp_r.dz, exp_r.ovf,
                     out_tdata, out_tuser[0], out_tuser[1], out_tuser[2]);
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the fixed-point ALU testbench: clock, reset, operand stimulus and the
// verdict. Depends on fpalu_pkg, fixed_point_alu and fpalu_checker.
module tb_top;
  import fpalu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [3:0]  in_tuser = OP_ADD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycle_count = 0;

  localparam longint CYCLE_LIMIT = 400000;

  always #1 clk = ~clk;

  fixed_point_alu dut (.*);

  fpalu_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(3) - 1;
      3: return $urandom_range(2047) - 1024;
      4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] edge_vals[6];
    int phase;
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00000100};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int op = 0; op < 16; op++)
      send_op(4'(op), edge_vals[op % 6], edge_vals[(op + 3) % 6]);
    send_op(OP_DIV, 32'h00000500, 32'h0);
    send_op(OP_DIV, 32'h80000000, 32'h00000001);
    send_op(OP_MUL, 32'h7fffffff, 32'h7fffffff);
    send_op(OP_MUL, 32'hffffff80, 32'h00000001);
    send_op(OP_MIN, 32'h00000005, 32'h00000005);
    send_op(OP_EQ, 32'h00000005, 32'h00000005);
    send_op(OP_FROM_INT, 32'hff000000, 32'h0);
    send_op(OP_TO_INT, 32'hfffffeff, 32'h0);
    for (int i = 0; i < 550; i++) begin
      phase = i / 138;
      send_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 30 : 0;
      recv_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 30 : 0;
      send_op(4'($urandom_range(15)), pick_operand(), pick_operand());
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/fpalu_pkg.sv
hdl/fpalu_divider.sv
hdl/fixed_point_alu.sv
tb/fpalu_checker.sv
tb/tb_top.sv
